/* rtl/lsp_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the lattice shell pixel kernel.
// Depends on nothing; every other file refers to it by scoped names.

package lsp_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_COS_A       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SIN_A       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COS_B       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SIN_B       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PITCH       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_MORPH       = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SHELL_COUNT = 3'd7;

    localparam logic signed [7:0] RST_COS_A       = 8'sd127;
    localparam logic signed [7:0] RST_SIN_A       = 8'sd0;
    localparam logic signed [7:0] RST_COS_B       = 8'sd127;
    localparam logic signed [7:0] RST_SIN_B       = 8'sd0;
    localparam logic [4:0]        RST_PITCH       = 5'd12;
    localparam logic [7:0]        RST_PHASE       = 8'd0;
    localparam logic [7:0]        RST_MORPH       = 8'd128;
    localparam logic [4:0]        RST_SHELL_COUNT = 5'd8;

    localparam logic [7:0]  FOLD_MID    = 8'd128;
    localparam logic [7:0]  RECIP_3     = 8'd171;
    localparam logic [11:0] RECIP_129   = 12'd4065;
    localparam logic [7:0]  BAND_SPAN   = 8'd129;
    localparam logic [7:0]  SEAM_LOW    = 8'd9;
    localparam logic [7:0]  SEAM_HIGH   = 8'd119;

    typedef struct packed {
        logic signed [7:0] pos_x;
        logic signed [7:0] pos_y;
        logic signed [7:0] pos_z;
    } in_item_t;

    typedef struct packed {
        logic [4:0] band;
        logic       on_seam;
    } out_item_t;

    typedef struct packed {
        logic signed [7:0] cos_a;
        logic signed [7:0] sin_a;
        logic signed [7:0] cos_b;
        logic signed [7:0] sin_b;
        logic [4:0]        pitch;
        logic [7:0]        phase;
        logic [7:0]        morph;
        logic [4:0]        shell_count;
    } cfg_t;

    typedef struct packed {
        logic signed [9:0]  qx;
        logic signed [16:0] nry;
        logic signed [16:0] nrz;
    } rot_t;

    typedef struct packed {
        logic [7:0] mx;
        logic [7:0] sm;
    } fold_t;

    // Signed divide by 128 that truncates toward zero.
    function automatic logic signed [9:0] div128(input logic signed [16:0] n);
        logic signed [16:0] t;
        begin
            t = n + (n[16] ? 17'sd127 : 17'sd0);
            return t[16:7];
        end
    endfunction

endpackage

/* rtl/lattice_shell_pixel_kernel.sv */
`timescale 1ns / 1ps
// Throughput: one item per cycle while the output is not stalled; every stage is a
// multiplier-sized step with its own valid.
// A stalled output holds the pipeline only as far back as needed, so bubbles are squeezed out.
// Reset clears all valid bits and restores the configuration registers to their defaults.
// Top level of the lattice shell pixel kernel: configuration registers and the
// rotate, fold and shell stages. Depends on lsp_pkg, lsp_rotate, lsp_fold and lsp_shell.

module lattice_shell_pixel_kernel (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [lsp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lsp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  lsp_pkg::in_item_t                  s_item,
    output logic                               m_valid,
    input  logic                               m_ready,
    output lsp_pkg::out_item_t                 m_item
);

    lsp_pkg::cfg_t  cfg_reg;
    lsp_pkg::rot_t  rot_data;
    lsp_pkg::fold_t fold_data;
    logic           rot_valid;
    logic           rot_ready;
    logic           fold_valid;
    logic           fold_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cos_a       <= lsp_pkg::RST_COS_A;
            cfg_reg.sin_a       <= lsp_pkg::RST_SIN_A;
            cfg_reg.cos_b       <= lsp_pkg::RST_COS_B;
            cfg_reg.sin_b       <= lsp_pkg::RST_SIN_B;
            cfg_reg.pitch       <= lsp_pkg::RST_PITCH;
            cfg_reg.phase       <= lsp_pkg::RST_PHASE;
            cfg_reg.morph       <= lsp_pkg::RST_MORPH;
            cfg_reg.shell_count <= lsp_pkg::RST_SHELL_COUNT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lsp_pkg::REG_COS_A:       cfg_reg.cos_a       <= cfg_wdata;
                lsp_pkg::REG_SIN_A:       cfg_reg.sin_a       <= cfg_wdata;
                lsp_pkg::REG_COS_B:       cfg_reg.cos_b       <= cfg_wdata;
                lsp_pkg::REG_SIN_B:       cfg_reg.sin_b       <= cfg_wdata;
                lsp_pkg::REG_PITCH:       cfg_reg.pitch       <= cfg_wdata[4:0];
                lsp_pkg::REG_PHASE:       cfg_reg.phase       <= cfg_wdata;
                lsp_pkg::REG_MORPH:       cfg_reg.morph       <= cfg_wdata;
                lsp_pkg::REG_SHELL_COUNT: cfg_reg.shell_count <= cfg_wdata[4:0];
                default: begin
                end
            endcase
        end
    end

    lsp_rotate u_rotate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_item),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .out_data  (rot_data)
    );

    lsp_fold u_fold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (rot_valid),
        .in_ready  (rot_ready),
        .in_data   (rot_data),
        .out_valid (fold_valid),
        .out_ready (fold_ready),
        .out_data  (fold_data)
    );

    lsp_shell u_shell (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (fold_valid),
        .in_ready  (fold_ready),
        .in_data   (fold_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (m_item)
    );

    // Input back-pressure can only come from a result that is waiting at the output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("lattice_shell_pixel_kernel: input stalled with output free");

endmodule

/* rtl/lsp_rotate.sv */
`timescale 1ns / 1ps
// Two pipeline stages of the two-axis rotation.
// Depends on lsp_pkg for the item, configuration and stage types.

module lsp_rotate (
    input  logic              aclk,
    input  logic              aresetn,
    input  lsp_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  lsp_pkg::in_item_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output lsp_pkg::rot_t     out_data
);

    logic               s1_valid_reg;
    logic               s2_valid_reg;
    logic               s1_ready;
    logic               s2_ready;

    logic signed [7:0]  px;
    logic signed [7:0]  py;
    logic signed [7:0]  pz;
    logic signed [16:0] nx_next;
    logic signed [16:0] ny_next;
    logic signed [16:0] nx_reg;
    logic signed [16:0] ny_reg;
    logic signed [7:0]  pz_reg;

    logic signed [9:0]  qy;
    logic signed [9:0]  qx_next;
    logic signed [16:0] nry_next;
    logic signed [16:0] nrz_next;
    logic signed [9:0]  qx_reg;
    logic signed [16:0] nry_reg;
    logic signed [16:0] nrz_reg;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign px = in_item.pos_x;
    assign py = in_item.pos_y;
    assign pz = in_item.pos_z;

    assign nx_next = px * cfg.cos_a - py * cfg.sin_a;
    assign ny_next = px * cfg.sin_a + py * cfg.cos_a;

    assign qy       = lsp_pkg::div128(ny_reg);
    assign qx_next  = lsp_pkg::div128(nx_reg);
    assign nry_next = qy * cfg.cos_b - pz_reg * cfg.sin_b;
    assign nrz_next = qy * cfg.sin_b + pz_reg * cfg.cos_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            nx_reg <= nx_next;
            ny_reg <= ny_next;
            pz_reg <= pz;
        end
        if (s2_ready && s1_valid_reg) begin
            qx_reg  <= qx_next;
            nry_reg <= nry_next;
            nrz_reg <= nrz_next;
        end
    end

    assign out_valid    = s2_valid_reg;
    assign out_data.qx  = qx_reg;
    assign out_data.nry = nry_reg;
    assign out_data.nrz = nrz_reg;

    // The first rotated axis never leaves twice the range of the input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg |-> (qx_reg <= 10'sd256 && qx_reg >= -10'sd256))
        else $error("lsp_rotate: rotated x out of range");

endmodule

/* rtl/lsp_fold.sv */
`timescale 1ns / 1ps
// Two pipeline stages: lattice fold of each axis, then max and mean norms.
// Depends on lsp_pkg for the configuration and stage types.

module lsp_fold (
    input  logic          aclk,
    input  logic          aresetn,
    input  lsp_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  lsp_pkg::rot_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output lsp_pkg::fold_t out_data
);

    logic              s3_valid_reg;
    logic              s4_valid_reg;
    logic              s3_ready;
    logic              s4_ready;

    logic signed [9:0] ry;
    logic signed [9:0] rz;
    logic [7:0]        ax_next;
    logic [7:0]        ay_next;
    logic [7:0]        az_next;
    logic [7:0]        ax_reg;
    logic [7:0]        ay_reg;
    logic [7:0]        az_reg;

    logic [7:0]        mx_xy;
    logic [7:0]        mx_next;
    logic [8:0]        sum3;
    logic [16:0]       sum_scaled;
    logic [7:0]        sm_next;
    logic [7:0]        mx_reg;
    logic [7:0]        sm_reg;

    function automatic logic [7:0] fold_axis(input logic [7:0] v, input logic [4:0] pitch,
                                             input logic [7:0] phase);
        logic [12:0] prod;
        logic [7:0]  w;
        begin
            prod = v * pitch;
            w    = prod[7:0] + phase;
            return w[7] ? {1'b0, w[6:0]} : (lsp_pkg::FOLD_MID - w);
        end
    endfunction

    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign in_ready = s3_ready;

    assign ry      = lsp_pkg::div128(in_data.nry);
    assign rz      = lsp_pkg::div128(in_data.nrz);
    assign ax_next = fold_axis(in_data.qx[7:0], cfg.pitch, cfg.phase);
    assign ay_next = fold_axis(ry[7:0], cfg.pitch, cfg.phase);
    assign az_next = fold_axis(rz[7:0], cfg.pitch, cfg.phase);

    assign mx_xy      = (ay_reg > ax_reg) ? ay_reg : ax_reg;
    assign mx_next    = (az_reg > mx_xy) ? az_reg : mx_xy;
    assign sum3       = {1'b0, ax_reg} + {1'b0, ay_reg} + {1'b0, az_reg};
    assign sum_scaled = sum3 * lsp_pkg::RECIP_3;
    assign sm_next    = sum_scaled[16:9];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            if (s3_ready) begin
                s3_valid_reg <= in_valid;
            end
            if (s4_ready) begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_ready && in_valid) begin
            ax_reg <= ax_next;
            ay_reg <= ay_next;
            az_reg <= az_next;
        end
        if (s4_ready && s3_valid_reg) begin
            mx_reg <= mx_next;
            sm_reg <= sm_next;
        end
    end

    assign out_valid   = s4_valid_reg;
    assign out_data.mx = mx_reg;
    assign out_data.sm = sm_reg;

endmodule

/* rtl/lsp_shell.sv */
`timescale 1ns / 1ps
// Three pipeline stages: norm blend, shell scaling, and band split with seam test.
// Depends on lsp_pkg for the configuration, stage and result types.

module lsp_shell (
    input  logic               aclk,
    input  logic               aresetn,
    input  lsp_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  lsp_pkg::fold_t     in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lsp_pkg::out_item_t out_item
);

    logic        s5_valid_reg;
    logic        s6_valid_reg;
    logic        s7_valid_reg;
    logic        s5_ready;
    logic        s6_ready;
    logic        s7_ready;

    logic [15:0] blend_mx;
    logic [15:0] blend_sm;
    logic [14:0] num_next;
    logic [14:0] num_reg;

    logic [15:0] div_sum;
    logic [7:0]  d_val;
    logic [12:0] t2_wide;
    logic [11:0] t2_next;
    logic [11:0] t2_reg;

    logic [23:0] band_prod;
    logic [4:0]  band_next;
    logic [11:0] band_base;
    logic [11:0] frac_wide;
    logic [7:0]  frac;
    logic        seam_next;
    lsp_pkg::out_item_t out_reg;

    assign s7_ready = !s7_valid_reg || out_ready;
    assign s6_ready = !s6_valid_reg || s7_ready;
    assign s5_ready = !s5_valid_reg || s6_ready;
    assign in_ready = s5_ready;

    assign blend_mx = in_data.mx * {8'd0, ~cfg.morph};
    assign blend_sm = in_data.sm * cfg.morph;
    assign num_next = blend_mx[14:0] + blend_sm[14:0];

    // Exact divide by 255 for a 15-bit dividend.
    assign div_sum = {1'b0, num_reg} + 16'd1 + {9'd0, num_reg[14:8]};
    assign d_val   = div_sum[15:8];
    assign t2_wide = d_val * cfg.shell_count;
    assign t2_next = t2_wide[11:0];

    // Divide by 129 through a reciprocal that is exact for dividends below 4096.
    assign band_prod = t2_reg * lsp_pkg::RECIP_129;
    assign band_next = band_prod[23:19];
    assign band_base = {band_next, 7'd0} + {7'd0, band_next};
    assign frac_wide = t2_reg - band_base;
    assign frac      = frac_wide[7:0];
    assign seam_next = (frac < lsp_pkg::SEAM_LOW) || (frac > lsp_pkg::SEAM_HIGH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end else begin
            if (s5_ready) begin
                s5_valid_reg <= in_valid;
            end
            if (s6_ready) begin
                s6_valid_reg <= s5_valid_reg;
            end
            if (s7_ready) begin
                s7_valid_reg <= s6_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s5_ready && in_valid) begin
            num_reg <= num_next;
        end
        if (s6_ready && s5_valid_reg) begin
            t2_reg <= t2_next;
        end
        if (s7_ready && s6_valid_reg) begin
            out_reg.band    <= band_next;
            out_reg.on_seam <= seam_next;
        end
    end

    assign out_valid = s7_valid_reg;
    assign out_item  = out_reg;

    // The blended distance stays within the fold's half period.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s5_valid_reg |-> (d_val <= lsp_pkg::FOLD_MID))
        else $error("lsp_shell: blended distance out of range");

    // The reciprocal split leaves a remainder below one band.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s6_valid_reg |-> (frac_wide < {4'd0, lsp_pkg::BAND_SPAN}))
        else $error("lsp_shell: band remainder out of range");

endmodule

/* tb/lsp_shell_checker.sv */
`timescale 1ns / 1ps
// Checker for the lattice shell pixel kernel. It watches the configuration port and both
// channels, predicts each pixel's band and seam flag, and compares them in order.
// Depends on lsp_pkg for the item, configuration and register index definitions.

module lsp_shell_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [lsp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lsp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  lsp_pkg::in_item_t               s_item,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  lsp_pkg::out_item_t              m_item,
    output int                              fail_count,
    output int                              pending,
    output int                              shells_checked
);

    typedef struct packed {
        lsp_pkg::in_item_t  pixel;
        lsp_pkg::out_item_t shell;
    } shell_expect_t;

    lsp_pkg::cfg_t shadow;
    shell_expect_t expected_shells[$];

    function automatic int fold_lattice(input int v, input int pitch, input int phase);
        int w;
        w = ((v * pitch) + phase) & 255;
        w = w - 128;
        return (w < 0) ? -w : w;
    endfunction

    function automatic lsp_pkg::out_item_t predict_shell(input lsp_pkg::in_item_t p,
                                                         input lsp_pkg::cfg_t c);
        int px, py, pz, ca, sa, cb, sb, pitch, phase, m, sc;
        int qx, qy, ry, rz, ax, ay, az, mx, sm, d, t2, band, frac;
        lsp_pkg::out_item_t r;
        px = p.pos_x;
        py = p.pos_y;
        pz = p.pos_z;
        ca = c.cos_a;
        sa = c.sin_a;
        cb = c.cos_b;
        sb = c.sin_b;
        pitch = c.pitch;
        phase = c.phase;
        m = c.morph;
        sc = c.shell_count;
        qx = (px * ca - py * sa) / 128;
        qy = (px * sa + py * ca) / 128;
        ry = (qy * cb - pz * sb) / 128;
        rz = (qy * sb + pz * cb) / 128;
        ax = fold_lattice(qx, pitch, phase);
        ay = fold_lattice(ry, pitch, phase);
        az = fold_lattice(rz, pitch, phase);
        mx = ax;
        if (ay > mx) mx = ay;
        if (az > mx) mx = az;
        sm = (ax + ay + az) / 3;
        d = (mx * (255 - m) + sm * m) / 255;
        t2 = d * sc;
        band = t2 / 129;
        frac = t2 - band * 129;
        r.band = band[4:0];
        r.on_seam = (frac < 9 || frac > 119);
        return r;
    endfunction

    initial begin
        fail_count = 0;
        pending = 0;
        shells_checked = 0;
    end

    always @(posedge aclk) begin : watch
        shell_expect_t e;
        if (!aresetn) begin
            shadow = '{cos_a: lsp_pkg::RST_COS_A, sin_a: lsp_pkg::RST_SIN_A,
                       cos_b: lsp_pkg::RST_COS_B, sin_b: lsp_pkg::RST_SIN_B,
                       pitch: lsp_pkg::RST_PITCH, phase: lsp_pkg::RST_PHASE,
                       morph: lsp_pkg::RST_MORPH, shell_count: lsp_pkg::RST_SHELL_COUNT};
            expected_shells.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    lsp_pkg::REG_COS_A:       shadow.cos_a = cfg_wdata;
                    lsp_pkg::REG_SIN_A:       shadow.sin_a = cfg_wdata;
                    lsp_pkg::REG_COS_B:       shadow.cos_b = cfg_wdata;
                    lsp_pkg::REG_SIN_B:       shadow.sin_b = cfg_wdata;
                    lsp_pkg::REG_PITCH:       shadow.pitch = cfg_wdata[4:0];
                    lsp_pkg::REG_PHASE:       shadow.phase = cfg_wdata;
                    lsp_pkg::REG_MORPH:       shadow.morph = cfg_wdata;
                    lsp_pkg::REG_SHELL_COUNT: shadow.shell_count = cfg_wdata[4:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                e.pixel = s_item;
                e.shell = predict_shell(s_item, shadow);
                expected_shells.push_back(e);
            end
            if (m_valid && m_ready) begin
                if (expected_shells.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result band %0d seam %0b", $realtime,
                                 m_item.band, m_item.on_seam);
                end else begin
                    e = expected_shells.pop_front();
                    shells_checked++;
                    if (e.shell.band !== m_item.band || e.shell.on_seam !== m_item.on_seam) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: pixel (%0d,%0d,%0d) band exp %0d got %0d,",
                                     $realtime, e.pixel.pos_x, e.pixel.pos_y, e.pixel.pos_z,
                                     e.shell.band, m_item.band,
                                     " seam exp %0b got %0b", e.shell.on_seam, m_item.on_seam);
                    end
                end
            end
        end
        pending = expected_shells.size();
    end

endmodule

/* tb/tb_lattice_shell_pixel_kernel.sv */
`timescale 1ns / 1ps
// Testbench top for the lattice shell pixel kernel: clock, reset, pixel and register stimulus,
// output stalls and the verdict. Depends on lsp_pkg, lsp_shell_checker and the kernel RTL.

module tb_lattice_shell_pixel_kernel;

    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 92;
    localparam int DIRECTED_ITEMS  = 20;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [lsp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [lsp_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    lsp_pkg::in_item_t               s_item = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    lsp_pkg::out_item_t              m_item;

    int   fail_count;
    int   pending;
    int   shells_checked;
    int   burst_left = 1;
    int   settings_used = 1;
    logic rx_holding = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    lattice_shell_pixel_kernel DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    lsp_shell_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .fail_count(fail_count), .pending(pending), .shells_checked(shells_checked)
    );

    function automatic logic [7:0] rand_coord();
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0: return 8'h80;
                1: return 8'h7F;
                2: return 8'h00;
                default: return 8'hFF;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic lsp_pkg::in_item_t directed_pixel(input int n);
        lsp_pkg::in_item_t p;
        if (n < 8) begin
            p.pos_x = n[0] ? 8'sd127 : -8'sd128;
            p.pos_y = n[1] ? 8'sd127 : -8'sd128;
            p.pos_z = n[2] ? 8'sd127 : -8'sd128;
            return p;
        end
        case (n)
            8:  p = '{8'sd0, 8'sd0, 8'sd0};
            9:  p = '{-8'sd1, -8'sd1, -8'sd1};
            10: p = '{8'sd1, 8'sd1, 8'sd1};
            11: p = '{8'sd127, 8'sd0, 8'sd0};
            12: p = '{8'sd0, 8'sd127, 8'sd0};
            13: p = '{8'sd0, 8'sd0, 8'sd127};
            14: p = '{-8'sd128, 8'sd0, 8'sd0};
            15: p = '{8'sd0, -8'sd128, 8'sd0};
            16: p = '{8'sd0, 8'sd0, -8'sd128};
            17: p = '{-8'sd1, 8'sd127, -8'sd128};
            18: p = '{8'sd85, -8'sd86, 8'sd42};
            default: p = '{8'sd64, -8'sd64, 8'sd32};
        endcase
        return p;
    endfunction

    function automatic lsp_pkg::cfg_t make_setting(input int p);
        lsp_pkg::cfg_t c;
        c.cos_a = 8'($urandom);
        c.sin_a = 8'($urandom);
        c.cos_b = 8'($urandom);
        c.sin_b = 8'($urandom);
        c.pitch = 5'($urandom_range(1, 31));
        c.phase = 8'($urandom);
        c.morph = 8'($urandom);
        c.shell_count = 5'($urandom_range(2, 17));
        case (p)
            1: c = '{-8'sd128, 8'sd127, -8'sd128, -8'sd128, 5'd31, 8'd255, 8'd255, 5'd17};
            2: c = '{8'sd127, -8'sd128, 8'sd127, 8'sd127, 5'd1, 8'd0, 8'd0, 5'd2};
            3: begin
                c.pitch = 5'd0;
                c.shell_count = 5'd0;
            end
            4: c.shell_count = 5'd1;
            5: begin
                c.shell_count = 5'd31;
                c.morph = 8'd255;
                c.pitch = 5'd31;
            end
            default: ;
        endcase
        return c;
    endfunction

    // Called at a falling edge; returns at a falling edge with the item accepted.
    task automatic offer_pixel(input lsp_pkg::in_item_t p);
        int gap;
        s_valid <= 1'b1;
        s_item <= p;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0 || rx_holding) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
    endtask

    task automatic write_settings(input lsp_pkg::cfg_t c);
        logic [lsp_pkg::CFG_INDEX_W-1:0] regs [8];
        logic [lsp_pkg::CFG_DATA_W-1:0]  vals [8];
        regs = '{lsp_pkg::REG_COS_A, lsp_pkg::REG_SIN_A, lsp_pkg::REG_COS_B,
                 lsp_pkg::REG_SIN_B, lsp_pkg::REG_PITCH, lsp_pkg::REG_PHASE,
                 lsp_pkg::REG_MORPH, lsp_pkg::REG_SHELL_COUNT};
        vals = '{c.cos_a, c.sin_a, c.cos_b, c.sin_b,
                 8'(c.pitch), c.phase, c.morph, 8'(c.shell_count)};
        for (int i = 0; i < 8; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= vals[i];
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic drain_results();
        int n;
        s_valid <= 1'b0;
        n = 0;
        while (pending != 0 && n < 5000) begin
            @(negedge aclk);
            n++;
        end
        repeat (12) @(negedge aclk);
    endtask

    initial begin : receiver
        int seg, len, mode, k;
        seg = 0;
        k = 0;
        forever begin
            mode = (seg % 5 == 4) ? 3 : $urandom_range(0, 2);
            len = $urandom_range(20, 100);
            if (mode == 3) begin
                @(negedge aclk);
                rx_holding <= 1'b1;
                m_ready <= 1'b0;
                repeat ($urandom_range(40, 80)) @(negedge aclk);
                rx_holding <= 1'b0;
            end else begin
                repeat (len) begin
                    @(negedge aclk);
                    k++;
                    case (mode)
                        0: m_ready <= 1'b1;
                        1: m_ready <= ($urandom_range(0, 9) > 2);
                        default: m_ready <= (k % 3 != 0);
                    endcase
                end
            end
            seg++;
        end
    end

    initial begin : stimulus
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        burst_left = $urandom_range(1, 40);
        for (int n = 0; n < DIRECTED_ITEMS; n++)
            offer_pixel(directed_pixel(n));
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                drain_results();
                write_settings(make_setting(p));
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                offer_pixel('{rand_coord(), rand_coord(), rand_coord()});
        end
        drain_results();
        repeat (20) @(negedge aclk);
        $display("Checked %0d pixel results over %0d register settings, including pitch zero,",
                 shells_checked, settings_used);
        $display("shell counts 0, 1, 17 and 31, rotation extremes and long output stalls.");
        if (fail_count == 0 && pending == 0) begin
            $display("tb_lattice_shell_pixel_kernel: PASS");
        end else begin
            $display("%0d failures, %0d expected results never arrived", fail_count, pending);
            $display("tb_lattice_shell_pixel_kernel: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("tb_lattice_shell_pixel_kernel: FAIL");
        $finish;
    end

endmodule
